[rtl/assert_macros.svh]
// Assertion macros shared by the channel state and top-level RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/hbpc_pkg.sv]
// Types, codes and constants of the dual H-bridge PWM command unit.
`timescale 1ns / 1ps

package hbpc_pkg;

    localparam int PCT_W      = 16;
    localparam int APPLIED_W  = 8;
    localparam int MAG_W      = 7;
    localparam int PERIOD_W   = 17;
    localparam int PROD_W     = 24;
    localparam int QIN_W      = PROD_W - 2;
    localparam int RECIP_W    = 23;
    localparam int RECIP_SHIFT = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 56;

    localparam logic signed [PCT_W-1:0]     PCT_HI     = 16'sd100;
    localparam logic signed [PCT_W-1:0]     PCT_LO     = -16'sd100;
    localparam logic signed [APPLIED_W-1:0] SAT_HI     = 8'sd100;
    localparam logic signed [APPLIED_W-1:0] SAT_LO     = -8'sd100;
    localparam logic [PROD_W-1:0]           ROUND_HALF = 24'd50;
    // ceil(2^27 / 25): exact quotient by 25 for any 22-bit dividend
    localparam logic [RECIP_W-1:0]          RECIP_25   = 23'd5368710;
    localparam logic [PERIOD_W-1:0]         PERIOD_RST = 17'd1000;

    localparam logic [1:0] DIR_NONE  = 2'b00;
    localparam logic [1:0] DIR_FWD   = 2'b01;
    localparam logic [1:0] DIR_REV   = 2'b10;
    localparam logic [1:0] DIR_BRAKE = 2'b11;

    typedef enum logic [2:0] {
        OP_SET_BOTH  = 3'd0,
        OP_SET_LEFT  = 3'd1,
        OP_SET_RIGHT = 3'd2,
        OP_COAST     = 3'd3,
        OP_BRAKE     = 3'd4,
        OP_ENABLE    = 3'd5,
        OP_DISABLE   = 3'd6
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD    = 2'd0,
        CFG_INV_LEFT  = 2'd1,
        CFG_INV_RIGHT = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ACT_KEEP  = 3'd0,
        ACT_COAST = 3'd1,
        ACT_BRAKE = 3'd2,
        ACT_DRIVE = 3'd3,
        ACT_CLEAR = 3'd4
    } ch_act_t;

    typedef struct packed {
        ch_act_t                     act;
        logic [1:0]                  dir;
        logic signed [APPLIED_W-1:0] applied;
        logic [PROD_W-1:0]           scaled;
    } ch_cmd_t;

endpackage

[rtl/hbpc_chan_prep.sv]
// Per-channel command preparation: saturate, invert, pick direction, scale by period.
`timescale 1ns / 1ps

module hbpc_chan_prep (
    input  logic signed [hbpc_pkg::PCT_W-1:0]    percent,
    input  logic                                 invert,
    input  logic        [hbpc_pkg::PERIOD_W-1:0] period,
    input  hbpc_pkg::ch_act_t                    req,
    output hbpc_pkg::ch_cmd_t                    cmd
);
    import hbpc_pkg::*;

    logic signed [APPLIED_W-1:0] sat;
    logic signed [APPLIED_W-1:0] dirn;
    logic        [MAG_W-1:0]     mag;

    always_comb begin
        if (percent > PCT_HI) begin
            sat = SAT_HI;
        end else if (percent < PCT_LO) begin
            sat = SAT_LO;
        end else begin
            sat = percent[APPLIED_W-1:0];
        end
        dirn = invert ? -sat : sat;
        mag  = dirn[APPLIED_W-1] ? MAG_W'(-dirn) : MAG_W'(dirn);

        cmd.act     = req;
        cmd.dir     = dirn[APPLIED_W-1] ? DIR_REV : DIR_FWD;
        cmd.applied = sat;
        cmd.scaled  = PROD_W'(period) * PROD_W'(mag) + ROUND_HALF;

        // zero command coasts the channel
        if (req == ACT_DRIVE && dirn == '0) begin
            cmd.act     = ACT_COAST;
            cmd.dir     = DIR_NONE;
            cmd.applied = '0;
        end
    end

endmodule

[rtl/hbpc_chan_state.sv]
// Per-channel state: divide the scaled command by 100 and hold pins, compare and command.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hbpc_chan_state (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  hbpc_pkg::ch_cmd_t                    cmd,
    input  logic        [hbpc_pkg::PERIOD_W-1:0] period,
    output logic        [1:0]                    pins,
    output logic        [hbpc_pkg::PERIOD_W-1:0] compare,
    output logic signed [hbpc_pkg::APPLIED_W-1:0] applied
);
    import hbpc_pkg::*;

    logic        [QIN_W-1:0]         qin;
    logic        [QIN_W+RECIP_W-1:0] recip_prod;
    logic        [PERIOD_W-1:0]      quot;

    logic        [1:0]           pins_reg,    pins_next;
    logic        [PERIOD_W-1:0]  compare_reg, compare_next;
    logic signed [APPLIED_W-1:0] applied_reg, applied_next;

    // x/100 = (x/4)/25
    assign qin        = cmd.scaled[PROD_W-1:2];
    assign recip_prod = (QIN_W+RECIP_W)'(qin) * (QIN_W+RECIP_W)'(RECIP_25);
    assign quot       = recip_prod[RECIP_SHIFT+PERIOD_W-1:RECIP_SHIFT];

    always_comb begin
        pins_next    = pins_reg;
        compare_next = compare_reg;
        applied_next = applied_reg;
        if (load) begin
            unique case (cmd.act)
                ACT_COAST: begin
                    pins_next    = DIR_NONE;
                    compare_next = period;
                    applied_next = '0;
                end
                ACT_BRAKE: begin
                    pins_next    = DIR_BRAKE;
                    compare_next = '0;
                    applied_next = '0;
                end
                ACT_DRIVE: begin
                    pins_next    = cmd.dir;
                    compare_next = quot;
                    applied_next = cmd.applied;
                end
                ACT_CLEAR: begin
                    pins_next    = DIR_NONE;
                    compare_next = '0;
                    applied_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pins_reg    <= DIR_NONE;
            compare_reg <= '0;
            applied_reg <= '0;
        end else begin
            pins_reg    <= pins_next;
            compare_reg <= compare_next;
            applied_reg <= applied_next;
        end
    end

    assign pins    = pins_reg;
    assign compare = compare_reg;
    assign applied = applied_reg;

    `ASSERT_IMPLIES(a_brake_zero_cmp, aclk, aresetn, pins_reg == DIR_BRAKE, compare_reg == '0)
    `ASSERT_IMPLIES(a_cmd_needs_drive, aclk, aresetn, applied_reg != '0,
                    pins_reg == DIR_FWD || pins_reg == DIR_REV)
    `ASSERT_NEXT(a_hold_without_load, aclk, aresetn, !load, $stable(compare_reg))

endmodule

[rtl/dual_hbridge_pwm_command_unit.sv]
// Top level of the dual H-bridge PWM command unit.
//
//  channel   | dir | beat payload
//  ----------+-----+------------------------------------------------------
//  s_ stream | in  | op, left speed command, right speed command
//  m_ stream | out | pins, compares, applied commands, enable flag
//  cfg       | in  | register index and data (period, invert bits)
//
// One command beat is taken every cycle unless a stalled result holds stage one full;
// a beat passes the stage-one register, then the channel state. Stage one decodes the
// op, updates the enable flag and forms period*|p|+50; stage two divides by 100 through
// a reciprocal multiply and updates the channel state, which is itself the result register.
// aresetn clears the enable flag, channel state and valids; config regs return
// to their reset values. A stalled result holds stage two, and stage one then fills.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dual_hbridge_pwm_command_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [2:0] op, [18:3] left_speed, [34:19] right_speed, [39:35] zero
    input  logic [hbpc_pkg::S_DATA_W-1:0]         s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [0] standby_release, [1] left_in_a, [2] left_in_b, [19:3] left_compare,
    // [20] right_in_a, [21] right_in_b, [38:22] right_compare,
    // [46:39] left_applied, [54:47] right_applied, [55] is_enabled
    output logic [hbpc_pkg::M_DATA_W-1:0]         m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hbpc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hbpc_pkg::PERIOD_W-1:0]         cfg_data
);
    import hbpc_pkg::*;

    op_t     op;
    ch_act_t req_l, req_r;
    ch_cmd_t cmd_l, cmd_r;
    logic    s_acc, adv2;

    logic                en_reg, en_next;
    logic                v1_reg, v1_next;
    logic                out_valid_reg, out_valid_next;
    logic                en1_reg;
    logic                en_out_reg;
    ch_cmd_t             cmd_l_reg, cmd_r_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic                inv_l_reg, inv_r_reg;

    logic        [1:0]           pins_l, pins_r;
    logic        [PERIOD_W-1:0]  cmp_l, cmp_r;
    logic signed [APPLIED_W-1:0] app_l, app_r;

    assign adv2     = v1_reg && (!out_valid_reg || m_tready);
    assign s_tready = !v1_reg || adv2;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign cfg_ready = 1'b1;

    assign op = op_t'(s_tdata[2:0]);

    always_comb begin
        req_l   = ACT_KEEP;
        req_r   = ACT_KEEP;
        en_next = en_reg;
        unique case (op)
            OP_SET_BOTH: begin
                if (en_reg) begin
                    req_l = ACT_DRIVE;
                    req_r = ACT_DRIVE;
                end
            end
            OP_SET_LEFT: begin
                if (en_reg) begin
                    req_l = ACT_DRIVE;
                end
            end
            OP_SET_RIGHT: begin
                if (en_reg) begin
                    req_r = ACT_DRIVE;
                end
            end
            OP_COAST: begin
                req_l = ACT_COAST;
                req_r = ACT_COAST;
            end
            OP_BRAKE: begin
                if (en_reg) begin
                    req_l = ACT_BRAKE;
                    req_r = ACT_BRAKE;
                end
            end
            OP_ENABLE: begin
                req_l   = ACT_COAST;
                req_r   = ACT_COAST;
                en_next = 1'b1;
            end
            OP_DISABLE: begin
                req_l   = ACT_CLEAR;
                req_r   = ACT_CLEAR;
                en_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    hbpc_chan_prep u_prep_l (
        .percent (s_tdata[18:3]),
        .invert  (inv_l_reg),
        .period  (period_reg),
        .req     (req_l),
        .cmd     (cmd_l)
    );

    hbpc_chan_prep u_prep_r (
        .percent (s_tdata[34:19]),
        .invert  (inv_r_reg),
        .period  (period_reg),
        .req     (req_r),
        .cmd     (cmd_r)
    );

    always_comb begin
        v1_next = v1_reg;
        if (s_acc) begin
            v1_next = 1'b1;
        end else if (adv2) begin
            v1_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (adv2) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            en_out_reg    <= 1'b0;
            period_reg    <= PERIOD_RST;
            inv_l_reg     <= 1'b1;
            inv_r_reg     <= 1'b0;
        end else begin
            v1_reg        <= v1_next;
            out_valid_reg <= out_valid_next;
            if (s_acc) begin
                en_reg <= en_next;
            end
            if (adv2) begin
                en_out_reg <= en1_reg;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_PERIOD:    period_reg <= cfg_data;
                    CFG_INV_LEFT:  inv_l_reg  <= cfg_data[0];
                    CFG_INV_RIGHT: inv_r_reg  <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // stage one payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            en1_reg   <= en_next;
            cmd_l_reg <= cmd_l;
            cmd_r_reg <= cmd_r;
        end
    end

    hbpc_chan_state u_state_l (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (adv2),
        .cmd     (cmd_l_reg),
        .period  (period_reg),
        .pins    (pins_l),
        .compare (cmp_l),
        .applied (app_l)
    );

    hbpc_chan_state u_state_r (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (adv2),
        .cmd     (cmd_r_reg),
        .period  (period_reg),
        .pins    (pins_r),
        .compare (cmp_r),
        .applied (app_r)
    );

    assign m_tdata = {en_out_reg, app_r, app_l, cmp_r, pins_r[1], pins_r[0],
                      cmp_l, pins_l[1], pins_l[0], en_out_reg};

    `ASSERT_IMPLIES(a_stall_needs_stage, aclk, aresetn, !s_tready, v1_reg && out_valid_reg)
    `ASSERT_NEXT(a_stage_holds, aclk, aresetn, v1_reg && !adv2, v1_reg && $stable(cmd_l_reg))
    `ASSERT_NEXT(a_adv_gives_result, aclk, aresetn, adv2, out_valid_reg)

endmodule

[test/tb.sv]
// Self-checking testbench for the dual H-bridge PWM command unit.
`timescale 1ns / 1ps

module tb;
    import hbpc_pkg::*;

    localparam logic [2:0]           OP_UNUSED    = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;
    localparam int                   CYCLE_LIMIT  = 400000;
    localparam int                   RX_HOLD_LEN  = 300;

    typedef struct {
        logic [2:0]              op;
        logic signed [PCT_W-1:0] left_pct;
        logic signed [PCT_W-1:0] right_pct;
    } bridge_cmd_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [PERIOD_W-1:0]    cfg_data  = '0;

    dual_hbridge_pwm_command_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block's registers and channel state
    logic [PERIOD_W-1:0]         period_sh;
    logic                        inv_left_sh;
    logic                        inv_right_sh;
    logic                        enabled_sh;
    logic [1:0]                  pins_sh [2];
    logic [PERIOD_W-1:0]         compare_sh [2];
    logic signed [APPLIED_W-1:0] applied_sh [2];

    bridge_cmd_t         pending_cmds [$];
    logic [M_DATA_W-1:0] expected_status [$];
    bridge_cmd_t         offered_cmd;

    int mismatches     = 0;
    int cycles         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold_left   = 0;
    logic rx_hold_go   = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void clear_bridges();
        period_sh    = PERIOD_RST;
        inv_left_sh  = 1'b1;
        inv_right_sh = 1'b0;
        enabled_sh   = 1'b0;
        for (int ch = 0; ch < 2; ch++) begin
            pins_sh[ch]    = DIR_NONE;
            compare_sh[ch] = '0;
            applied_sh[ch] = '0;
        end
    endfunction

    function automatic void coast_channel(int ch);
        pins_sh[ch]    = DIR_NONE;
        compare_sh[ch] = period_sh;
        applied_sh[ch] = '0;
    endfunction

    function automatic void brake_channel(int ch);
        pins_sh[ch]    = DIR_BRAKE;
        compare_sh[ch] = '0;
        applied_sh[ch] = '0;
    endfunction

    function automatic void drive_channel(int ch, logic signed [PCT_W-1:0] pct, logic inv);
        int sat;
        int p;
        int mag;
        sat = pct;
        if (sat > 100) sat = 100;
        if (sat < -100) sat = -100;
        p = inv ? -sat : sat;
        if (p == 0) begin
            coast_channel(ch);
        end else begin
            pins_sh[ch]    = (p > 0) ? DIR_FWD : DIR_REV;
            mag            = (p > 0) ? p : -p;
            compare_sh[ch] = PERIOD_W'((int'(period_sh) * mag + 50) / 100);
        end
        applied_sh[ch] = APPLIED_W'(sat);
    endfunction

    function automatic logic [M_DATA_W-1:0] step_bridges(bridge_cmd_t c);
        case (c.op)
            OP_SET_BOTH: begin
                if (enabled_sh) begin
                    drive_channel(0, c.left_pct, inv_left_sh);
                    drive_channel(1, c.right_pct, inv_right_sh);
                end
            end
            OP_SET_LEFT:  if (enabled_sh) drive_channel(0, c.left_pct, inv_left_sh);
            OP_SET_RIGHT: if (enabled_sh) drive_channel(1, c.right_pct, inv_right_sh);
            OP_COAST: begin
                coast_channel(0);
                coast_channel(1);
            end
            OP_BRAKE: begin
                if (enabled_sh) begin
                    brake_channel(0);
                    brake_channel(1);
                end
            end
            OP_ENABLE: begin
                coast_channel(0);
                coast_channel(1);
                enabled_sh = 1'b1;
            end
            OP_DISABLE: begin
                enabled_sh = 1'b0;
                for (int ch = 0; ch < 2; ch++) begin
                    pins_sh[ch]    = DIR_NONE;
                    compare_sh[ch] = '0;
                    applied_sh[ch] = '0;
                end
            end
            default: ;
        endcase
        return {enabled_sh, applied_sh[1], applied_sh[0], compare_sh[1], pins_sh[1],
                compare_sh[0], pins_sh[0], enabled_sh};
    endfunction

    function automatic bridge_cmd_t make_cmd(logic [2:0] op, int lp, int rp);
        bridge_cmd_t c;
        c.op        = op;
        c.left_pct  = PCT_W'(lp);
        c.right_pct = PCT_W'(rp);
        return c;
    endfunction

    function automatic int random_pct();
        int r;
        r = $urandom_range(99);
        if (r < 55) return $urandom_range(220) - 110;
        if (r < 65) return 0;
        if (r < 80) return (r & 1) ? 32767 : -32768;
        return $signed(PCT_W'($urandom));
    endfunction

    function automatic bridge_cmd_t random_cmd();
        int r;
        logic [2:0] op;
        r = $urandom_range(99);
        if (r < 25)      op = OP_SET_BOTH;
        else if (r < 43) op = OP_SET_LEFT;
        else if (r < 61) op = OP_SET_RIGHT;
        else if (r < 71) op = OP_ENABLE;
        else if (r < 79) op = OP_BRAKE;
        else if (r < 87) op = OP_COAST;
        else if (r < 94) op = OP_DISABLE;
        else             op = OP_UNUSED;
        return make_cmd(op, random_pct(), random_pct());
    endfunction

    // sender: hold the beat until taken, idle at random between beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            clear_bridges();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PERIOD:    period_sh    = cfg_data;
                    CFG_INV_LEFT:  inv_left_sh  = cfg_data[0];
                    CFG_INV_RIGHT: inv_right_sh = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_status.push_back(step_bridges(offered_cmd));
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, offered_cmd.right_pct, offered_cmd.left_pct,
                                 offered_cmd.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each result beat against the oldest prediction
    always @(posedge aclk) begin
        logic [M_DATA_W-1:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("result beat with nothing pending", m_tdata, 0);
                end else begin
                    want = expected_status.pop_front();
                    if (m_tdata[0] !== want[0])
                        report_mismatch("standby_release", m_tdata[0], want[0]);
                    if (m_tdata[1] !== want[1])
                        report_mismatch("left_in_a", m_tdata[1], want[1]);
                    if (m_tdata[2] !== want[2])
                        report_mismatch("left_in_b", m_tdata[2], want[2]);
                    if (m_tdata[19:3] !== want[19:3])
                        report_mismatch("left_compare", m_tdata[19:3], want[19:3]);
                    if (m_tdata[20] !== want[20])
                        report_mismatch("right_in_a", m_tdata[20], want[20]);
                    if (m_tdata[21] !== want[21])
                        report_mismatch("right_in_b", m_tdata[21], want[21]);
                    if (m_tdata[38:22] !== want[38:22])
                        report_mismatch("right_compare", m_tdata[38:22], want[38:22]);
                    if (m_tdata[46:39] !== want[46:39])
                        report_mismatch("left_applied", $signed(m_tdata[46:39]),
                                        $signed(want[46:39]));
                    if (m_tdata[54:47] !== want[54:47])
                        report_mismatch("right_applied", $signed(m_tdata[54:47]),
                                        $signed(want[54:47]));
                    if (m_tdata[55] !== want[55])
                        report_mismatch("is_enabled", m_tdata[55], want[55]);
                end
            end
            m_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
        else if (rx_hold_go)
            rx_hold_left <= RX_HOLD_LEN;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // sample on the falling edge so the sender's queue and valid agree
    task automatic drain();
        while (pending_cmds.size() != 0 || s_tvalid || expected_status.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
            pending_cmds.push_back(random_cmd());
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // gated while disabled, then every op and the saturation edges
        pending_cmds.push_back(make_cmd(OP_SET_BOTH, 100, -100));
        pending_cmds.push_back(make_cmd(OP_BRAKE, 0, 0));
        pending_cmds.push_back(make_cmd(OP_COAST, 0, 0));
        pending_cmds.push_back(make_cmd(OP_UNUSED, 7, -7));
        pending_cmds.push_back(make_cmd(OP_ENABLE, 0, 0));
        pending_cmds.push_back(make_cmd(OP_SET_BOTH, 100, -100));
        pending_cmds.push_back(make_cmd(OP_SET_BOTH, 32767, -32768));
        pending_cmds.push_back(make_cmd(OP_SET_LEFT, 0, 55));
        pending_cmds.push_back(make_cmd(OP_SET_RIGHT, 55, -1));
        pending_cmds.push_back(make_cmd(OP_SET_BOTH, 1, 0));
        pending_cmds.push_back(make_cmd(OP_SET_LEFT, -101, 0));
        pending_cmds.push_back(make_cmd(OP_SET_RIGHT, 0, 101));
        pending_cmds.push_back(make_cmd(OP_BRAKE, 3, 3));
        pending_cmds.push_back(make_cmd(OP_SET_BOTH, 50, 49));
        pending_cmds.push_back(make_cmd(OP_COAST, 0, 0));
        pending_cmds.push_back(make_cmd(OP_UNUSED, 0, 0));
        pending_cmds.push_back(make_cmd(OP_DISABLE, 0, 0));
        pending_cmds.push_back(make_cmd(OP_SET_LEFT, 5, 5));
        pending_cmds.push_back(make_cmd(OP_ENABLE, 0, 0));
        pending_cmds.push_back(make_cmd(OP_SET_BOTH, -32768, 32767));
        pending_cmds.push_back(make_cmd(OP_ENABLE, 0, 0));
        pending_cmds.push_back(make_cmd(OP_SET_BOTH, -1, 1));
        pending_cmds.push_back(make_cmd(OP_DISABLE, 0, 0));
        drain();

        write_reg(CFG_PERIOD, 17'd1);
        write_reg(CFG_INV_LEFT, 17'd0);
        write_reg(CFG_INV_RIGHT, 17'd0);
        random_phase(90, 0, 0);

        write_reg(CFG_PERIOD, 17'd65536);
        write_reg(CFG_INV_LEFT, 17'h1fffe);
        write_reg(CFG_INV_RIGHT, 17'h1ffff);
        random_phase(90, 73, 0);

        write_reg(CFG_PERIOD, 17'd0);
        write_reg(CFG_INV_RIGHT, 17'd1);
        write_reg(CFG_UNUSED, PERIOD_W'($urandom));
        random_phase(90, 0, 73);

        write_reg(CFG_PERIOD, 17'h1ffff);
        write_reg(CFG_INV_LEFT, 17'd1);
        random_phase(90, 32, 32);

        // long receiver hold while the sender keeps offering beats
        write_reg(CFG_PERIOD, PERIOD_W'($urandom_range(65536, 1)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 60; i++)
            pending_cmds.push_back(random_cmd());
        rx_hold_go <= 1'b1;
        while (rx_hold_left == 0) @(posedge aclk);
        rx_hold_go <= 1'b0;
        drain();

        write_reg(CFG_PERIOD, PERIOD_W'($urandom_range(2000, 1)));
        write_reg(CFG_INV_LEFT, 17'd0);
        random_phase(60, 0, 0);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
